>>> rtl/core/brip_pkg.sv
// brip_pkg: widths, accumulator op codes and shared structs of the brake run
// integrator and peak tracker. No dependencies; imported by every module of
// the block.
package brip_pkg;

    // sample field width (input channels, peaks, acceleration)
    localparam int SAMPLE_BITS = 24;
    localparam int FORCE_W     = SAMPLE_BITS + 1;
    localparam int ASUM_W      = 48;
    localparam int VSUM_W      = 64;
    localparam int OUT_W48     = 48;

    // configuration widths
    localparam int STEP_W      = 24;
    localparam int DEC_W       = 16;
    localparam int APB_AW      = 3;
    localparam int APB_DW      = 32;

    // shared multiplier: 25 x 25 signed, Q0.24 chunks of 24 bits
    localparam int CHUNK_W     = 24;
    localparam int MUL_W       = CHUNK_W + 1;
    localparam int PROD_W      = 2 * MUL_W;
    localparam int ACC_W       = 66;

    // stream payload widths (whole bytes)
    localparam int IN_DATA_W   = 6 * SAMPLE_BITS;
    localparam int OUT_FIELD_W = 4 * SAMPLE_BITS + FORCE_W + 2 * OUT_W48;
    localparam int OUT_DATA_W  = ((OUT_FIELD_W + 7) / 8) * 8;
    localparam int OUT_PAD_W   = OUT_DATA_W - OUT_FIELD_W;

    // register indexes
    localparam logic REG_STEP_TIME  = 1'b0;
    localparam logic REG_DECIMATION = 1'b1;

    // accumulator operation applied to the registered product
    typedef enum logic [2:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_LOAD_HI,
        ACC_ADD,
        ACC_ADD_LO
    } t_acc_op;

    typedef struct packed {
        logic signed [MUL_W-1:0] mul_a;
        t_acc_op                 op;
    } t_mac_ctl;

    typedef struct packed {
        logic [STEP_W-1:0] step_time;
        logic [DEC_W-1:0]  decimation;
    } t_cfg;

endpackage

>>> rtl/core/brip_regs.sv
// brip_regs: APB-style configuration registers (step time, decimation).
// Depends on brip_pkg.
module brip_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [brip_pkg::APB_AW-1:0] paddr,
    input  logic [brip_pkg::APB_DW-1:0] pwdata,
    output logic [brip_pkg::APB_DW-1:0] prdata,
    output logic                        pready,
    output brip_pkg::t_cfg              o_cfg
);
    import brip_pkg::*;

    logic [STEP_W-1:0] r_step_time;
    logic [DEC_W-1:0]  r_decimation;
    logic              w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;

    // write on the access cycle; register index is the word address
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_time  <= STEP_W'(16777);
            r_decimation <= DEC_W'(99);
        end else if (w_wr) begin
            case (paddr[2])
                REG_STEP_TIME:  r_step_time  <= pwdata[STEP_W-1:0];
                REG_DECIMATION: r_decimation <= pwdata[DEC_W-1:0];
                default: ;
            endcase
        end
    end

    // read back
    always_comb begin
        case (paddr[2])
            REG_STEP_TIME:  prdata = APB_DW'(r_step_time);
            REG_DECIMATION: prdata = APB_DW'(r_decimation);
            default:        prdata = '0;
        endcase
    end

    assign o_cfg.step_time  = r_step_time;
    assign o_cfg.decimation = r_decimation;

endmodule

>>> rtl/core/brip_mac.sv
// brip_mac: shared 25x25 multiplier with registered product and a wide
// accumulator that assembles Q0.24 products chunk by chunk. Depends on brip_pkg.
module brip_mac (
    input  logic                           i_clk,
    input  brip_pkg::t_mac_ctl             i_ctl,
    input  logic [brip_pkg::STEP_W-1:0]    i_step,
    output logic signed [brip_pkg::ACC_W-1:0] o_acc
);
    import brip_pkg::*;

    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [MUL_W-1:0]  w_step_s;
    logic signed [ACC_W-1:0]  w_prod_x;

    assign w_step_s = signed'({1'b0, i_step});
    assign w_prod_x = ACC_W'(r_prod);

    // multiply stage
    always_ff @(posedge i_clk) begin
        r_prod <= i_ctl.mul_a * w_step_s;
    end

    // accumulate stage on last cycle's product
    always_ff @(posedge i_clk) begin
        case (i_ctl.op)
            ACC_HOLD:    r_acc <= r_acc;
            ACC_LOAD:    r_acc <= w_prod_x;
            ACC_LOAD_HI: r_acc <= w_prod_x <<< CHUNK_W;
            ACC_ADD:     r_acc <= r_acc + w_prod_x;
            ACC_ADD_LO:  r_acc <= r_acc + (w_prod_x >>> CHUNK_W);
            default:     r_acc <= r_acc;
        endcase
    end

    assign o_acc = r_acc;

endmodule

>>> rtl/core/brip_div.sv
// brip_div: restoring divider, one quotient bit per cycle, signed 64-bit
// dividend by unsigned count, truncating toward zero. Depends on brip_pkg.
module brip_div #(
    parameter int CW = 25
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_start,
    input  logic signed [brip_pkg::VSUM_W-1:0]     i_num,
    input  logic [CW-1:0]                          i_den,
    output logic                                   o_busy,
    output logic signed [brip_pkg::VSUM_W:0]       o_quot
);
    import brip_pkg::*;

    localparam int STEPS = VSUM_W;
    localparam int SC_W  = $clog2(STEPS);

    logic              r_busy;
    logic              r_neg;
    logic [VSUM_W-1:0] r_q;
    logic [CW-1:0]     r_rem;
    logic [CW-1:0]     r_den;
    logic [SC_W-1:0]   r_cnt;
    logic [VSUM_W-1:0] w_abs;
    logic [CW:0]       w_shift;
    logic [CW:0]       w_diff;
    logic              w_ge;
    logic signed [VSUM_W:0] w_q65;

    assign w_abs   = i_num[VSUM_W-1] ? (~i_num + VSUM_W'(1)) : i_num;
    assign w_shift = {r_rem, r_q[VSUM_W-1]};
    assign w_ge    = w_shift >= {1'b0, r_den};
    assign w_diff  = w_shift - {1'b0, r_den};

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + SC_W'(1);
            if (r_cnt == SC_W'(STEPS - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // shift and subtract datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= w_abs;
            r_rem <= '0;
            r_den <= i_den;
            r_neg <= i_num[VSUM_W-1];
        end else if (r_busy) begin
            r_q   <= {r_q[VSUM_W-2:0], w_ge};
            r_rem <= w_ge ? w_diff[CW-1:0] : w_shift[CW-1:0];
        end
    end

    assign w_q65  = signed'({1'b0, r_q});
    assign o_quot = r_neg ? -w_q65 : w_q65;
    assign o_busy = r_busy;

endmodule

>>> rtl/core/brake_run_integrator_peak_tracker.sv
// brake_run_integrator_peak_tracker: top level with the row sequencer, run
// state, peaks and the output register. Uses brip_pkg, brip_regs, brip_mac
// and brip_div.
//
//  channel   | dir | handshake               | payload
//  ----------+-----+-------------------------+-------------------------------
//  s_axis    | in  | s_axis_tvalid/tready    | tdata: 6 samples, tlast: last
//  m_axis    | out | m_axis_tvalid/tready    | tdata: 7 fields, tuser: kind,
//            |     |                         | tlast: last result of the row
//  apb       | in  | psel/penable/pready     | step_time @0, decimation @4
//
// A row that ends no run passes the five sequencer steps through the shared
// multiplier and the saturating adders, and an emit step when it emits a trace
// beat. The last row of a run goes on: distance goes through the multiplier
// again and the mean velocity waits on the 64-step divider.
// Reset is synchronous, active low, and clears the run state, the sequencer, the
// configuration registers and the output valid flag. The result sits in an output
// register; the next row is taken while it stalls, and emission of the next row's beat waits for the slot to drain.
module brake_run_integrator_peak_tracker #(
    parameter int MAX_RUN_SAMPLES = 16777216
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // s_axis_tdata: accel_sample, force_high, force_low, tilt_x, tilt_y,
    //               pedal_pos (24 bits each, lowest first)
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [brip_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    input  logic                             s_axis_tlast,
    // m_axis_tdata: accel_value, velocity_value, force_value, pedal_value,
    //               distance_value, peak_tilt_x, peak_tilt_y, zero pad
    // m_axis_tuser: kind
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [brip_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    output logic                             m_axis_tuser,
    output logic                             m_axis_tlast,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [brip_pkg::APB_AW-1:0]      paddr,
    input  logic [brip_pkg::APB_DW-1:0]      pwdata,
    output logic [brip_pkg::APB_DW-1:0]      prdata,
    output logic                             pready
);
    import brip_pkg::*;

    localparam int CNT_W = $clog2(MAX_RUN_SAMPLES + 1);
    localparam int ST_W  = 4;

    localparam logic [ST_W-1:0] ST_IDLE   = 4'd0;
    localparam logic [ST_W-1:0] ST_VHI    = 4'd1;
    localparam logic [ST_W-1:0] ST_VLO    = 4'd2;
    localparam logic [ST_W-1:0] ST_VACC   = 4'd3;
    localparam logic [ST_W-1:0] ST_VSAT   = 4'd4;
    localparam logic [ST_W-1:0] ST_VSUM   = 4'd5;
    localparam logic [ST_W-1:0] ST_D2     = 4'd6;
    localparam logic [ST_W-1:0] ST_D1     = 4'd7;
    localparam logic [ST_W-1:0] ST_D0     = 4'd8;
    localparam logic [ST_W-1:0] ST_DACC   = 4'd9;
    localparam logic [ST_W-1:0] ST_DSAT   = 4'd10;
    localparam logic [ST_W-1:0] ST_DWAIT  = 4'd11;
    localparam logic [ST_W-1:0] ST_MEAN   = 4'd12;
    localparam logic [ST_W-1:0] ST_EMIT_T = 4'd13;
    localparam logic [ST_W-1:0] ST_EMIT_S = 4'd14;

    // saturate a wide signed value to 48 bits
    function automatic logic signed [OUT_W48-1:0] sat48(input logic signed [ACC_W-1:0] x);
        logic signed [ACC_W-1:0] hi_lim;
        logic signed [ACC_W-1:0] lo_lim;
        hi_lim = 66'sd140737488355327;
        lo_lim = -66'sd140737488355328;
        if (x > hi_lim) begin
            sat48 = {1'b0, {(OUT_W48-1){1'b1}}};
        end else if (x < lo_lim) begin
            sat48 = {1'b1, {(OUT_W48-1){1'b0}}};
        end else begin
            sat48 = x[OUT_W48-1:0];
        end
    endfunction

    t_cfg      w_cfg;
    t_mac_ctl  w_mac_ctl;
    logic signed [ACC_W-1:0]  w_mac_acc;
    logic                     w_div_busy;
    logic signed [VSUM_W:0]   w_quot;

    logic [ST_W-1:0] r_state;
    logic [ST_W-1:0] n_state;

    // run state
    logic signed [ASUM_W-1:0]      r_accel_sum;
    logic signed [VSUM_W-1:0]      r_vsum;
    logic signed [FORCE_W-1:0]     r_peak_force;
    logic signed [SAMPLE_BITS-1:0] r_peak_x;
    logic signed [SAMPLE_BITS-1:0] r_peak_y;
    logic signed [SAMPLE_BITS-1:0] r_peak_pedal;
    logic [CNT_W-1:0]              r_run_count;
    logic                          r_first;
    logic [DEC_W-1:0]              r_decim_count;

    // row being worked on
    logic signed [SAMPLE_BITS-1:0] r_acc_in;
    logic signed [FORCE_W-1:0]     r_force;
    logic                          r_trace;
    logic                          r_last;
    logic signed [OUT_W48-1:0]     r_vel;
    logic signed [OUT_W48-1:0]     r_dist;
    logic signed [OUT_W48-1:0]     r_mean;

    // output register
    logic                          r_ov;
    logic                          r_o_kind;
    logic                          r_o_last;
    logic signed [SAMPLE_BITS-1:0] r_o_acc;
    logic signed [OUT_W48-1:0]     r_o_vel;
    logic signed [FORCE_W-1:0]     r_o_force;
    logic signed [SAMPLE_BITS-1:0] r_o_pedal;
    logic signed [OUT_W48-1:0]     r_o_dist;
    logic signed [SAMPLE_BITS-1:0] r_o_px;
    logic signed [SAMPLE_BITS-1:0] r_o_py;

    logic                          w_accept;
    logic                          w_slot_free;
    logic                          w_load_t;
    logic                          w_load_s;
    logic signed [SAMPLE_BITS-1:0] w_acc;
    logic signed [SAMPLE_BITS-1:0] w_fh;
    logic signed [SAMPLE_BITS-1:0] w_fl;
    logic signed [SAMPLE_BITS-1:0] w_tx;
    logic signed [SAMPLE_BITS-1:0] w_ty;
    logic signed [SAMPLE_BITS-1:0] w_pd;
    logic signed [FORCE_W-1:0]     w_force;
    logic signed [ASUM_W:0]        w_asum_x;
    logic signed [ASUM_W-1:0]      w_asum_sat;
    logic signed [VSUM_W:0]        w_vsum_x;
    logic signed [VSUM_W-1:0]      w_vsum_sat;
    logic                          w_trace;

    brip_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    brip_mac u_mac (
        .i_clk  (i_clk),
        .i_ctl  (w_mac_ctl),
        .i_step (w_cfg.step_time),
        .o_acc  (w_mac_acc)
    );

    brip_div #(
        .CW (CNT_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == ST_D2),
        .i_num   (r_vsum),
        .i_den   (r_run_count),
        .o_busy  (w_div_busy),
        .o_quot  (w_quot)
    );

    // unpack the input beat
    assign w_acc   = s_axis_tdata[0*SAMPLE_BITS +: SAMPLE_BITS];
    assign w_fh    = s_axis_tdata[1*SAMPLE_BITS +: SAMPLE_BITS];
    assign w_fl    = s_axis_tdata[2*SAMPLE_BITS +: SAMPLE_BITS];
    assign w_tx    = s_axis_tdata[3*SAMPLE_BITS +: SAMPLE_BITS];
    assign w_ty    = s_axis_tdata[4*SAMPLE_BITS +: SAMPLE_BITS];
    assign w_pd    = s_axis_tdata[5*SAMPLE_BITS +: SAMPLE_BITS];
    assign w_force = FORCE_W'(w_fh) - FORCE_W'(w_fl);

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_slot_free   = !r_ov || m_axis_tready;
    assign w_load_t      = (r_state == ST_EMIT_T) && w_slot_free;
    assign w_load_s      = (r_state == ST_EMIT_S) && w_slot_free;
    assign w_trace       = r_decim_count >= w_cfg.decimation;

    // saturating acceleration sum
    assign w_asum_x   = (ASUM_W + 1)'(r_accel_sum) + (ASUM_W + 1)'(w_acc);
    assign w_asum_sat = (w_asum_x[ASUM_W] != w_asum_x[ASUM_W-1])
                      ? {w_asum_x[ASUM_W], {(ASUM_W-1){!w_asum_x[ASUM_W]}}}
                      : w_asum_x[ASUM_W-1:0];

    // saturating velocity sum
    assign w_vsum_x   = (VSUM_W + 1)'(r_vsum) + (VSUM_W + 1)'(r_vel);
    assign w_vsum_sat = (w_vsum_x[VSUM_W] != w_vsum_x[VSUM_W-1])
                      ? {w_vsum_x[VSUM_W], {(VSUM_W-1){!w_vsum_x[VSUM_W]}}}
                      : w_vsum_x[VSUM_W-1:0];

    // drive the shared multiplier: issue a chunk, fold in the last product
    always_comb begin
        w_mac_ctl.mul_a = '0;
        w_mac_ctl.op    = ACC_HOLD;
        case (r_state)
            ST_VHI: begin
                w_mac_ctl.mul_a = MUL_W'(signed'(r_accel_sum[ASUM_W-1:CHUNK_W]));
            end
            ST_VLO: begin
                w_mac_ctl.mul_a = signed'({1'b0, r_accel_sum[CHUNK_W-1:0]});
                w_mac_ctl.op    = ACC_LOAD;
            end
            ST_VACC: begin
                w_mac_ctl.op    = ACC_ADD_LO;
            end
            ST_D2: begin
                w_mac_ctl.mul_a = MUL_W'(signed'(r_vsum[VSUM_W-1:2*CHUNK_W]));
            end
            ST_D1: begin
                w_mac_ctl.mul_a = signed'({1'b0, r_vsum[2*CHUNK_W-1:CHUNK_W]});
                w_mac_ctl.op    = ACC_LOAD_HI;
            end
            ST_D0: begin
                w_mac_ctl.mul_a = signed'({1'b0, r_vsum[CHUNK_W-1:0]});
                w_mac_ctl.op    = ACC_ADD;
            end
            ST_DACC: begin
                w_mac_ctl.op    = ACC_ADD_LO;
            end
            default: ;
        endcase
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:   if (w_accept) n_state = ST_VHI;
            ST_VHI:    n_state = ST_VLO;
            ST_VLO:    n_state = ST_VACC;
            ST_VACC:   n_state = ST_VSAT;
            ST_VSAT:   n_state = ST_VSUM;
            ST_VSUM: begin
                if (r_last) begin
                    n_state = ST_D2;
                end else if (r_trace) begin
                    n_state = ST_EMIT_T;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_D2:     n_state = ST_D1;
            ST_D1:     n_state = ST_D0;
            ST_D0:     n_state = ST_DACC;
            ST_DACC:   n_state = ST_DSAT;
            ST_DSAT:   n_state = ST_DWAIT;
            ST_DWAIT:  if (!w_div_busy) n_state = ST_MEAN;
            ST_MEAN:   n_state = r_trace ? ST_EMIT_T : ST_EMIT_S;
            ST_EMIT_T: if (w_slot_free) n_state = r_last ? ST_EMIT_S : ST_IDLE;
            ST_EMIT_S: if (w_slot_free) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // run state: take the row, integrate, hold peaks, clear after summary
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accel_sum   <= '0;
            r_vsum        <= '0;
            r_peak_force  <= '0;
            r_peak_x      <= '0;
            r_peak_y      <= '0;
            r_peak_pedal  <= '0;
            r_run_count   <= '0;
            r_first       <= 1'b1;
            r_decim_count <= '0;
        end else if (w_accept) begin
            r_accel_sum <= w_asum_sat;
            if (r_first || (w_force > r_peak_force)) r_peak_force <= w_force;
            if (r_first || (w_tx > r_peak_x))        r_peak_x     <= w_tx;
            if (r_first || (w_ty > r_peak_y))        r_peak_y     <= w_ty;
            if (r_first || (w_pd > r_peak_pedal))    r_peak_pedal <= w_pd;
            r_first <= 1'b0;
            if (r_run_count < CNT_W'(MAX_RUN_SAMPLES)) begin
                r_run_count <= r_run_count + CNT_W'(1);
            end
            r_decim_count <= w_trace ? '0 : r_decim_count + DEC_W'(1);
        end else if (r_state == ST_VSUM) begin
            r_vsum <= w_vsum_sat;
        end else if (w_load_s) begin
            r_accel_sum  <= '0;
            r_vsum       <= '0;
            r_peak_force <= '0;
            r_peak_x     <= '0;
            r_peak_y     <= '0;
            r_peak_pedal <= '0;
            r_run_count  <= '0;
            r_first      <= 1'b1;
        end
    end

    // per-row working values
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_acc_in <= w_acc;
            r_force  <= w_force;
            r_trace  <= w_trace;
            r_last   <= s_axis_tlast;
        end
        if (r_state == ST_VSAT) r_vel  <= sat48(w_mac_acc);
        if (r_state == ST_DSAT) r_dist <= sat48(w_mac_acc);
        if (r_state == ST_MEAN) r_mean <= sat48(ACC_W'(w_quot));
    end

    // output register: valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_load_t || w_load_s) begin
            r_ov <= 1'b1;
        end else if (m_axis_tready) begin
            r_ov <= 1'b0;
        end
    end

    // output register: payload
    always_ff @(posedge i_clk) begin
        if (w_load_t) begin
            r_o_kind  <= 1'b0;
            r_o_last  <= !r_last;
            r_o_acc   <= r_acc_in;
            r_o_vel   <= r_vel;
            r_o_force <= r_force;
            r_o_pedal <= r_peak_pedal;
            r_o_dist  <= '0;
            r_o_px    <= '0;
            r_o_py    <= '0;
        end else if (w_load_s) begin
            r_o_kind  <= 1'b1;
            r_o_last  <= 1'b1;
            r_o_acc   <= r_acc_in;
            r_o_vel   <= r_mean;
            r_o_force <= r_peak_force;
            r_o_pedal <= r_peak_pedal;
            r_o_dist  <= r_dist;
            r_o_px    <= r_peak_x;
            r_o_py    <= r_peak_y;
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tuser  = r_o_kind;
    assign m_axis_tlast  = r_o_last;
    assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, r_o_py, r_o_px, r_o_dist, r_o_pedal,
                            r_o_force, r_o_vel, r_o_acc};

    // a taken row always starts the velocity pass
    a_accept_starts : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == ST_VHI))
        else $error("accepted row did not start the velocity pass");

    // no row is taken while the mean division runs
    a_div_blocks : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_busy |-> !s_axis_tready)
        else $error("input ready while divider busy");

    // a summary beat always closes the row
    a_summary_last : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> m_axis_tlast)
        else $error("summary beat without tlast");

    // the run state is cleared once the summary is loaded
    a_run_cleared : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load_s |=> (r_first && (r_run_count == '0) && (r_vsum == '0)))
        else $error("run state not cleared after summary");

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps
// tb: self-checking bench for brake_run_integrator_peak_tracker; drives sample rows on
// s_axis, programs step_time and decimation over APB and checks every m_axis beat.
// Depends on brip_pkg and the block's RTL only.
module tb;
    import brip_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 100;
    localparam int RUN_CAP        = 16777216;
    localparam int ROWS_PER_PHASE = 100;

    localparam bit KIND_TRACE   = 1'b0;
    localparam bit KIND_SUMMARY = 1'b1;

    localparam logic signed [SAMPLE_BITS-1:0] S_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] S_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    localparam longint HI48 = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint LO48 = -HI48 - 1;
    localparam longint HI64 = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam longint LO64 = -HI64 - 1;

    // field offsets inside m_axis_tdata, lowest field first
    localparam int OFF_VEL  = SAMPLE_BITS;
    localparam int OFF_FRC  = OFF_VEL + OUT_W48;
    localparam int OFF_PED  = OFF_FRC + FORCE_W;
    localparam int OFF_DIST = OFF_PED + SAMPLE_BITS;
    localparam int OFF_PX   = OFF_DIST + OUT_W48;
    localparam int OFF_PY   = OFF_PX + SAMPLE_BITS;

    typedef struct {
        logic signed [SAMPLE_BITS-1:0] accel;
        logic signed [SAMPLE_BITS-1:0] f_hi;
        logic signed [SAMPLE_BITS-1:0] f_lo;
        logic signed [SAMPLE_BITS-1:0] tilt_x;
        logic signed [SAMPLE_BITS-1:0] tilt_y;
        logic signed [SAMPLE_BITS-1:0] pedal;
        logic                          end_of_run;
    } t_brake_row;

    typedef struct {
        logic                   kind;
        logic [SAMPLE_BITS-1:0] accel;
        logic [OUT_W48-1:0]     velocity;
        logic [FORCE_W-1:0]     force_v;
        logic [SAMPLE_BITS-1:0] pedal;
        logic [OUT_W48-1:0]     distance;
        logic [SAMPLE_BITS-1:0] tilt_x;
        logic [SAMPLE_BITS-1:0] tilt_y;
        logic                   last;
    } t_brake_beat;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // accel, force_high, force_low, tilt_x, tilt_y, pedal_pos (lowest first)
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                  s_axis_tlast = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // accel, velocity, force, pedal, distance, tilt_x peak, tilt_y peak, pad
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    // kind
    logic                  m_axis_tuser;
    logic                  m_axis_tlast;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_AW-1:0]     paddr = '0;
    logic [APB_DW-1:0]     pwdata = '0;
    logic [APB_DW-1:0]     prdata;
    logic                  pready;

    brake_run_integrator_peak_tracker dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // run state mirrored by the predictor
    logic [STEP_W-1:0] cfg_step  = 24'd16777;
    logic [DEC_W-1:0]  cfg_decim = 16'd99;
    int                decim_ctr = 0;
    longint            accel_total = 0;
    longint            vel_total = 0;
    longint            pk_force = 0;
    longint            pk_x = 0;
    longint            pk_y = 0;
    longint            pk_pedal = 0;
    int                rows_in_run = 0;
    bit                fresh_run = 1'b1;

    t_brake_beat due_beats[$];
    int          fail_count = 0;
    bit          tx_steady = 1'b0;
    bit          rx_steady = 1'b0;

    function automatic longint clamp48(logic signed [95:0] v);
        if (v > HI48) return HI48;
        if (v < LO48) return LO48;
        return v[63:0];
    endfunction

    // floor(a * s / 2^24)
    function automatic logic signed [95:0] scale_q24(longint a, logic [STEP_W-1:0] s);
        logic signed [95:0] wa;
        logic signed [95:0] ws;
        wa = 96'(a);
        ws = {72'd0, s};
        return (wa * ws) >>> 24;
    endfunction

    function automatic longint add_sat64(longint a, longint b);
        logic signed [64:0] t;
        t = 65'(a) + 65'(b);
        if (t > HI64) return HI64;
        if (t < LO64) return LO64;
        return t[63:0];
    endfunction

    // integrate one row, update peaks and queue the trace and summary beats it causes
    task automatic predict_row(t_brake_row r);
        longint      acc;
        longint      frc;
        longint      vel;
        longint      brake_len;
        logic signed [95:0] wide;
        bit          trace;
        t_brake_beat b;
        acc  = longint'(r.accel);
        frc  = longint'(r.f_hi) - longint'(r.f_lo);
        wide = 96'(accel_total) + 96'(acc);
        accel_total = clamp48(wide);
        vel = clamp48(scale_q24(accel_total, cfg_step));
        vel_total = add_sat64(vel_total, vel);
        brake_len = clamp48(scale_q24(vel_total, cfg_step));

        // seed peaks from the first row, then keep strictly larger values
        if (fresh_run) begin
            pk_force  = frc;
            pk_x      = longint'(r.tilt_x);
            pk_y      = longint'(r.tilt_y);
            pk_pedal  = longint'(r.pedal);
            fresh_run = 1'b0;
        end
        if (frc > pk_force) pk_force = frc;
        if (longint'(r.tilt_x) > pk_x) pk_x = longint'(r.tilt_x);
        if (longint'(r.tilt_y) > pk_y) pk_y = longint'(r.tilt_y);
        if (longint'(r.pedal) > pk_pedal) pk_pedal = longint'(r.pedal);
        if (rows_in_run < RUN_CAP) rows_in_run++;

        trace = decim_ctr >= int'(cfg_decim);
        if (trace) decim_ctr = 0;
        else decim_ctr++;

        if (trace) begin
            b.kind     = KIND_TRACE;
            b.accel    = SAMPLE_BITS'(acc);
            b.velocity = OUT_W48'(vel);
            b.force_v  = FORCE_W'(frc);
            b.pedal    = SAMPLE_BITS'(pk_pedal);
            b.distance = '0;
            b.tilt_x   = '0;
            b.tilt_y   = '0;
            b.last     = !r.end_of_run;
            due_beats.insert(due_beats.size(), b);
        end
        if (r.end_of_run) begin
            b.kind     = KIND_SUMMARY;
            b.accel    = SAMPLE_BITS'(acc);
            b.velocity = OUT_W48'(clamp48(vel_total / longint'(rows_in_run)));
            b.force_v  = FORCE_W'(pk_force);
            b.pedal    = SAMPLE_BITS'(pk_pedal);
            b.distance = OUT_W48'(brake_len);
            b.tilt_x   = SAMPLE_BITS'(pk_x);
            b.tilt_y   = SAMPLE_BITS'(pk_y);
            b.last     = 1'b1;
            due_beats.insert(due_beats.size(), b);
            // clear the run, keep the decimation count
            accel_total = 0;
            vel_total   = 0;
            pk_force    = 0;
            pk_x        = 0;
            pk_y        = 0;
            pk_pedal    = 0;
            rows_in_run = 0;
            fresh_run   = 1'b1;
        end
    endtask

    function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0: return S_MAX;
            1: return S_MIN;
            2: return '0;
            3: return '1;
            default: return SAMPLE_BITS'($urandom);
        endcase
    endfunction

    function automatic t_brake_row make_row(logic signed [SAMPLE_BITS-1:0] a,
                                            logic signed [SAMPLE_BITS-1:0] fh,
                                            logic signed [SAMPLE_BITS-1:0] fl,
                                            logic signed [SAMPLE_BITS-1:0] tx,
                                            logic signed [SAMPLE_BITS-1:0] ty,
                                            logic signed [SAMPLE_BITS-1:0] pd,
                                            logic fin);
        t_brake_row r;
        r.accel      = a;
        r.f_hi       = fh;
        r.f_lo       = fl;
        r.tilt_x     = tx;
        r.tilt_y     = ty;
        r.pedal      = pd;
        r.end_of_run = fin;
        return r;
    endfunction

    function automatic t_brake_row random_row(logic fin);
        return make_row(pick_sample(), pick_sample(), pick_sample(), pick_sample(),
                        pick_sample(), pick_sample(), fin);
    endfunction

    // send one row; with hold set, first pause until every queued beat has drained
    task automatic send_row(t_brake_row r, bit hold = 1'b0);
        int gap;
        if (hold) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
            while (due_beats.size() != 0) @(posedge i_clk);
        end
        gap = tx_steady ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {r.pedal, r.tilt_y, r.tilt_x, r.f_lo, r.f_hi, r.accel};
        s_axis_tlast  <= r.end_of_run;
        do @(posedge i_clk); while (!s_axis_tready);
        predict_row(r);
    endtask

    // drop valid, drain all expected beats, then let any row without a result finish
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (due_beats.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_write(logic idx, logic [APB_DW-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_AW'(4 * int'(idx));
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_STEP_TIME) cfg_step = value[STEP_W-1:0];
        else cfg_decim = value[DEC_W-1:0];
        @(posedge i_clk);
    endtask

    task automatic configure(logic [STEP_W-1:0] step, logic [DEC_W-1:0] decim);
        wait_idle();
        apb_write(REG_STEP_TIME, APB_DW'(step));
        apb_write(REG_DECIMATION, APB_DW'(decim));
    endtask

    // field extremes, trace and summary on one row, single-row runs
    task automatic test_extreme_rows();
        configure(24'hFFFFFF, 16'd0);
        send_row(make_row(S_MAX, S_MAX, S_MAX, S_MAX, S_MAX, S_MAX, 1'b0));
        send_row(make_row(S_MIN, S_MIN, S_MIN, S_MIN, S_MIN, S_MIN, 1'b0));
        send_row(make_row('0, S_MAX, S_MIN, '0, '0, '0, 1'b0));
        send_row(make_row('0, S_MIN, S_MAX, '0, '0, '0, 1'b0));
        send_row(make_row('0, '0, '0, '0, '0, '0, 1'b0));
        send_row(make_row('1, '1, '1, '1, '1, '1, 1'b0));
        send_row(random_row(1'b1));
        // single-row run with negative seeds, after a full drain
        send_row(make_row(S_MIN, S_MIN, S_MAX, S_MIN, S_MIN, S_MIN, 1'b1), 1'b1);
        send_row(make_row(S_MAX, '0, '0, S_MAX, '0, S_MIN, 1'b1));
        configure(24'd1, 16'd2);
        for (int i = 0; i < 6; i++) send_row(random_row(i == 5));
    endtask

    // count survives the end of a run; a lower decimation forces the next trace
    task automatic test_decimation_rewrite();
        configure(24'hFFFFFF, 16'hFFFF);
        for (int i = 0; i < 10; i++) send_row(random_row(i == 4));
        configure(24'd16777, 16'd3);
        for (int i = 0; i < 6; i++) send_row(random_row(i == 5));
    endtask

    // full-scale acceleration over a long run builds large velocity and distance sums
    task automatic test_long_run_saturation();
        configure(24'hFFFFFF, 16'hFFFF);
        tx_steady = 1'b1;
        for (int i = 0; i < 600; i++) begin
            send_row(make_row(S_MAX, pick_sample(), pick_sample(), pick_sample(),
                              pick_sample(), pick_sample(), i == 599));
        end
        tx_steady = 1'b0;
    endtask

    // well-formed runs of random length and content under changing settings
    task automatic test_random_runs();
        logic [STEP_W-1:0] step;
        logic [DEC_W-1:0]  decim;
        int                sent;
        int                run_len;
        for (int phase = 0; phase < 6; phase++) begin
            case ($urandom_range(0, 3))
                0: step = 24'd1;
                1: step = 24'hFFFFFF;
                2: step = 24'd16777;
                default: step = STEP_W'($urandom_range(1, 24'hFFFFFF));
            endcase
            case ($urandom_range(0, 5))
                0: decim = 16'd0;
                1: decim = 16'hFFFF;
                2: decim = DEC_W'($urandom_range(0, 16'hFFFF));
                default: decim = DEC_W'($urandom_range(0, 7));
            endcase
            configure(step, decim);
            tx_steady = (phase % 3) == 1;
            rx_steady = (phase % 3) == 2;
            sent = 0;
            while (sent < ROWS_PER_PHASE) begin
                run_len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3)
                                                      : $urandom_range(4, 40);
                for (int i = 0; i < run_len; i++) begin
                    send_row(random_row(i == run_len - 1), $urandom_range(0, 63) == 0);
                end
                sent += run_len;
            end
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    // result side: random stall before each beat, none while rx_steady is set
    initial begin
        int stall;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            stall = rx_steady ? 0 : $urandom_range(0, 19);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
        end
    end

    task automatic check_field(string what, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            fail_count++;
            $display("%0t %s mismatch: expected %h actual %h", $time, what, want, got);
        end
    endtask

    task automatic check_beat();
        t_brake_beat want;
        if (due_beats.size() == 0) begin
            fail_count++;
            $display("%0t unexpected beat: expected none actual %h", $time, m_axis_tdata);
            return;
        end
        want = due_beats.pop_front();
        check_field("kind", want.kind, m_axis_tuser);
        check_field("accel", want.accel, m_axis_tdata[0 +: SAMPLE_BITS]);
        check_field("velocity", want.velocity, m_axis_tdata[OFF_VEL +: OUT_W48]);
        check_field("force", want.force_v, m_axis_tdata[OFF_FRC +: FORCE_W]);
        check_field("pedal", want.pedal, m_axis_tdata[OFF_PED +: SAMPLE_BITS]);
        check_field("distance", want.distance, m_axis_tdata[OFF_DIST +: OUT_W48]);
        check_field("tilt_x", want.tilt_x, m_axis_tdata[OFF_PX +: SAMPLE_BITS]);
        check_field("tilt_y", want.tilt_y, m_axis_tdata[OFF_PY +: SAMPLE_BITS]);
        check_field("last", want.last, m_axis_tlast);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) check_beat();
    end

    // end the run when no beat or register access moves for too long
    int quiet_cycles = 0;
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (psel && penable)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL brake_run_integrator_peak_tracker");
            $finish;
        end
    end

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_extreme_rows();
        test_decimation_rewrite();
        test_long_run_saturation();
        test_random_runs();
        wait_idle();
        if (fail_count == 0 && due_beats.size() == 0) begin
            $display("PASS brake_run_integrator_peak_tracker");
        end else begin
            $display("FAIL brake_run_integrator_peak_tracker");
        end
        $finish;
    end

endmodule
